@@ design/gaussian_spot_texel_generator_assert.svh @@
// Assertion macros used by the checker of the spot texel generator
`ifndef GAUSSIAN_SPOT_TEXEL_GENERATOR_ASSERT_SVH
`define GAUSSIAN_SPOT_TEXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, masked during reset
`define GSTG_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define GSTG_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live during reset
`define GSTG_ASSERT_RST_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ant) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gstg_pkg.sv @@
// Package of the spot texel generator: widths, constants, register codes, table
`timescale 1ns / 1ps

package gstg_pkg;

    localparam int MAX_LOG2_SIZE = 8;

    localparam int ROW_W      = 8;
    localparam int COL_W      = 8;
    localparam int INT_W      = 8;
    localparam int LOG2_W     = 4;
    localparam int FALL_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF_COEFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_GAIN     = 2'd2;

    localparam logic [LOG2_W-1:0] RST_LOG2_SIZE     = 4'd8;
    localparam logic [FALL_W-1:0] RST_FALLOFF_COEFF = 32'd7888;
    localparam logic [GAIN_W-1:0] RST_PEAK_GAIN     = 24'd3282680;

    localparam int D_W   = (MAX_LOG2_SIZE > ROW_W) ? MAX_LOG2_SIZE : ROW_W;
    localparam int R2_W  = 2 * D_W + 1;
    localparam int ARG_W = R2_W + FALL_W;

    localparam int ARG_FRAC_W = 24;
    localparam int ARG_KEEP_W = ARG_FRAC_W + 5;

    localparam int                LOG2E_W   = 31;
    localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;
    localparam int                T_SHIFT   = 30;
    localparam int                T_W       = ARG_KEEP_W + LOG2E_W - T_SHIFT;
    localparam int                K_W       = T_W - ARG_FRAC_W;

    localparam int IDX_W  = 4;
    localparam int REM_W  = ARG_FRAC_W - IDX_W;
    localparam int M_W    = 17;
    localparam int DIFF_W = 12;

    localparam int P_W = M_W + GAIN_W;
    localparam int G_W = 36;

    localparam int             Q_W       = 15;
    localparam logic [Q_W-1:0] SCALE_NUM = 15'd25599;
    localparam logic [Q_W-1:0] RECIP_100 = 15'd20972;
    localparam int             RECIP_SH  = 21;

    localparam int NSTG = 8;

    typedef struct packed {
        logic [M_W-1:0] m;
        logic [K_W-1:0] k;
    } t_exp2_res;

    function automatic logic [M_W-1:0] exp2_frac(input logic [IDX_W:0] idx);
        logic [M_W-1:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

@@ design/gstg_texel_if.sv @@
// Channel interface carrying texel coordinates into the generator
`timescale 1ns / 1ps

interface gstg_texel_if
    import gstg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;

    modport source (output valid, output row, output col, input ready);
    modport sink (input valid, input row, input col, output ready);
endinterface

@@ design/gstg_spot_if.sv @@
// Channel interface carrying spot luminance out of the generator
`timescale 1ns / 1ps

interface gstg_spot_if
    import gstg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [INT_W-1:0] intensity;

    modport source (output valid, output intensity, input ready);
    modport sink (input valid, input intensity, output ready);
endinterface

@@ design/gstg_exp2_interp.sv @@
// Fractional power-of-two lookup with linear interpolation between table entries
`timescale 1ns / 1ps

module gstg_exp2_interp
    import gstg_pkg::*;
(
    input  logic [T_W-1:0] i_t,
    output t_exp2_res      o_res
);

    logic [IDX_W-1:0]        w_idx;
    logic [REM_W-1:0]        w_rem;
    logic [M_W-1:0]          w_hi;
    logic [M_W-1:0]          w_lo;
    logic [M_W-1:0]          w_diff;
    logic [DIFF_W+REM_W-1:0] w_prod;

    assign w_idx  = i_t[ARG_FRAC_W-1:REM_W];
    assign w_rem  = i_t[REM_W-1:0];
    assign w_hi   = exp2_frac({1'b0, w_idx});
    assign w_lo   = exp2_frac({1'b0, w_idx} + 5'd1);
    assign w_diff = w_hi - w_lo;
    assign w_prod = w_diff[DIFF_W-1:0] * w_rem;

    assign o_res.m = w_hi - M_W'(w_prod[DIFF_W+REM_W-1:REM_W]);
    assign o_res.k = i_t[T_W-1:ARG_FRAC_W];

endmodule

@@ design/gaussian_spot_texel_generator.sv @@
// Gaussian spot texel generator: eight-stage fixed-point pipeline from texel to luminance
`timescale 1ns / 1ps

// One texel enters per clock unless the input stalls, and its luminance passes through
// the eight register stages that split the squared radius, the falloff multiply,
// the log2(e) multiply, the table interpolation, the gain multiply, the power-of-two
// shift and the two output scaling multiplies. Each stage holds only while the stage
// after it is full and stalled, so empty slots fill under backpressure and the input
// stalls only when every stage is occupied and the output is not taken. Configuration
// writes take effect at once and belong between frames while the pipeline is empty.

module gaussian_spot_texel_generator
    import gstg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gstg_texel_if.sink            i_texel,
    gstg_spot_if.source           o_spot,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [LOG2_W-1:0] r_log2_size;
    logic [FALL_W-1:0] r_falloff_coeff;
    logic [GAIN_W-1:0] r_peak_gain;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_en;

    logic [LOG2_W-1:0] w_eff;
    logic [D_W-1:0]    w_half;
    logic [D_W-1:0]    w_row;
    logic [D_W-1:0]    w_col;
    logic [D_W-1:0]    w_dy;
    logic [D_W-1:0]    w_dx;

    logic [R2_W-1:0]           n_r2, r_r2;
    logic [ARG_W-1:0]          w_arg;
    logic [ARG_KEEP_W-1:0]     n_arg, r_arg;
    logic                      n_huge1, r_huge1;
    logic [ARG_KEEP_W+LOG2E_W-1:0] w_tprod;
    logic [T_W-1:0]            n_t, r_t;
    logic                      r_huge2;
    t_exp2_res                 n_er, r_er;
    logic                      r_huge3;
    logic [P_W-1:0]            n_p, r_p;
    logic [K_W-1:0]            r_k4;
    logic                      r_huge4;
    logic [P_W-1:0]            w_gfull;
    logic [G_W-1:0]            n_g, r_g;
    logic                      n_sat5, r_sat5;
    logic                      r_huge5;
    logic [G_W+Q_W-1:0]        w_qprod;
    logic [Q_W-1:0]            n_q, r_q;
    logic                      r_sat6;
    logic                      r_huge6;
    logic [2*Q_W-1:0]          w_rprod;
    logic [INT_W-1:0]          n_out, r_out;

    function automatic logic [ARG_W-1:0] n_arg_src(input logic [R2_W-1:0] r2,
                                                    input logic [FALL_W-1:0] c);
        return ARG_W'(r2) * ARG_W'(c);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_size     <= RST_LOG2_SIZE;
            r_falloff_coeff <= RST_FALLOFF_COEFF;
            r_peak_gain     <= RST_PEAK_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOG2_SIZE:     r_log2_size     <= i_cfg_data[LOG2_W-1:0];
                CFG_FALLOFF_COEFF: r_falloff_coeff <= i_cfg_data[FALL_W-1:0];
                CFG_PEAK_GAIN:     r_peak_gain     <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the stage after it advances
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_spot.ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) n_vld[0] = i_texel.valid;
        for (int s = 1; s < NSTG; s++) begin
            if (w_en[s]) n_vld[s] = r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_texel.ready   = w_en[0];
    assign o_spot.valid    = r_vld[NSTG-1];
    assign o_spot.intensity = r_out;

    // stage 0: offsets from the centre and squared radius
    always_comb begin
        if (r_log2_size < LOG2_W'(1)) begin
            w_eff = LOG2_W'(1);
        end else if (r_log2_size > LOG2_W'(MAX_LOG2_SIZE)) begin
            w_eff = LOG2_W'(MAX_LOG2_SIZE);
        end else begin
            w_eff = r_log2_size;
        end
        w_half = D_W'(1) << (w_eff - LOG2_W'(1));
        w_row  = D_W'(i_texel.row);
        w_col  = D_W'(i_texel.col);
        w_dy   = (w_row >= w_half) ? (w_row - w_half) : (w_half - w_row);
        w_dx   = (w_col >= w_half) ? (w_col - w_half) : (w_half - w_col);
        n_r2   = (R2_W'(w_dy) * R2_W'(w_dy)) + (R2_W'(w_dx) * R2_W'(w_dx));
    end

    // stage 1: falloff multiply
    assign w_arg   = n_arg_src(r_r2, r_falloff_coeff);
    assign n_arg   = w_arg[ARG_KEEP_W-1:0];
    assign n_huge1 = |w_arg[ARG_W-1:ARG_KEEP_W];

    // stage 2: scale by log2(e)
    assign w_tprod = r_arg * LOG2E_Q30;
    assign n_t     = w_tprod[ARG_KEEP_W+LOG2E_W-1:T_SHIFT];

    // stage 3: fractional power of two
    gstg_exp2_interp u_exp2 (
        .i_t   (r_t),
        .o_res (n_er)
    );

    // stage 4: peak gain multiply
    assign n_p = r_er.m * r_peak_gain;

    // stage 5: integer power of two as a right shift, then flag saturation
    assign w_gfull = r_p >> r_k4;
    assign n_g     = w_gfull[G_W-1:0];
    assign n_sat5  = |w_gfull[P_W-1:G_W];

    // stage 6: scale by 25599 (255.99 times one hundred), drop the fraction
    assign w_qprod = r_g * SCALE_NUM;
    assign n_q     = w_qprod[G_W+Q_W-1:G_W];

    // stage 7: divide by one hundred and clamp
    assign w_rprod = r_q * RECIP_100;
    always_comb begin
        if (r_huge6) begin
            n_out = '0;
        end else if (r_sat6) begin
            n_out = '1;
        end else begin
            n_out = w_rprod[RECIP_SH+INT_W-1:RECIP_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_r2 <= n_r2;
        end
        if (w_en[1]) begin
            r_arg   <= n_arg;
            r_huge1 <= n_huge1;
        end
        if (w_en[2]) begin
            r_t     <= n_t;
            r_huge2 <= r_huge1;
        end
        if (w_en[3]) begin
            r_er    <= n_er;
            r_huge3 <= r_huge2;
        end
        if (w_en[4]) begin
            r_p     <= n_p;
            r_k4    <= r_er.k;
            r_huge4 <= r_huge3;
        end
        if (w_en[5]) begin
            r_g     <= n_g;
            r_sat5  <= n_sat5;
            r_huge5 <= r_huge4;
        end
        if (w_en[6]) begin
            r_q     <= n_q;
            r_sat6  <= r_sat5;
            r_huge6 <= r_huge5;
        end
        if (w_en[7]) begin
            r_out <= n_out;
        end
    end

endmodule

@@ design/gstg_checker.sv @@
// Port-level checker for the spot texel generator and its bind
`timescale 1ns / 1ps
`include "gaussian_spot_texel_generator_assert.svh"

module gstg_checker
    import gstg_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [INT_W-1:0] i_intensity
);

    `GSTG_ASSERT_RST_NXT(a_rst_out_idle, !i_rst_n, !i_out_valid, "output valid after reset")
    `GSTG_ASSERT_RST_NXT(a_rst_in_ready, !i_rst_n, i_in_ready, "input not ready after reset")
    `GSTG_ASSERT_IMP(a_stall_cause, !i_in_ready, i_out_valid && !i_out_ready,
        "input stalled without output backpressure")
    `GSTG_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_intensity), "stalled output transaction changed")

endmodule

bind gaussian_spot_texel_generator gstg_checker u_gstg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_texel.valid),
    .i_in_ready  (i_texel.ready),
    .i_out_valid (o_spot.valid),
    .i_out_ready (o_spot.ready),
    .i_intensity (o_spot.intensity)
);
